// ----- rtl/pbo_pkg.sv -----
`timescale 1ns / 1ps
package pbo_pkg;

	localparam int PHASE_BITS_DEF       = 24;
	localparam int SAMPLE_FRAC_BITS_DEF = 15;

	localparam int FREQ_W   = 24;
	localparam int TUNE_W   = 16;
	localparam int PERIOD_W = 32;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [TUNE_W-1:0]   TUNE_RST   = 16'd16384;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 32'd89478;

	typedef enum logic [1:0] {
		WAVE_SAW = 2'd0,
		WAVE_TRI = 2'd1,
		WAVE_SQR = 2'd2,
		WAVE_OFF = 2'd3
	} wave_t;

	typedef enum logic [1:0] {
		REG_WAVE   = 2'd0,
		REG_TUNE   = 2'd1,
		REG_PERIOD = 2'd2
	} reg_idx_t;

endpackage

// ----- rtl/pbo_if.sv -----
`timescale 1ns / 1ps
interface pbo_in_if #(
	parameter int PHASE_BITS = 24
);
	logic                  valid;
	logic                  ready;
	logic [PHASE_BITS-1:0] phase_in;
	logic [23:0]           freq_hz;

	modport source (output valid, output phase_in, output freq_hz, input ready);
	modport sink   (input valid, input phase_in, input freq_hz, output ready);
endinterface

interface pbo_out_if #(
	parameter int PHASE_BITS       = 24,
	parameter int SAMPLE_FRAC_BITS = 15
);
	logic                               valid;
	logic                               ready;
	logic [PHASE_BITS-1:0]              phase_out;
	logic signed [SAMPLE_FRAC_BITS+2:0] sample_out;

	modport source (output valid, output phase_out, output sample_out, input ready);
	modport sink   (input valid, input phase_out, input sample_out, output ready);
endinterface

// ----- rtl/polyblep_oscillator_sample.sv -----
`timescale 1ns / 1ps
// Pipeline: SAMPLE_FRAC_BITS + 7 register stages from the input to the output register.
// Throughput: one transaction per cycle; three stages form the increment, one selects the
// branches, one stage per quotient bit in the two restoring dividers, then square and sum.
// A stalled output holds the whole pipeline.
// Reset (arst_n low, asynchronous) clears valid bits and loads register defaults.
module polyblep_oscillator_sample
	import pbo_pkg::*;
#(
	parameter int PHASE_BITS       = PHASE_BITS_DEF,
	parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	pbo_in_if.sink             in_ch,
	pbo_out_if.source          out_ch
);

	localparam int P         = PHASE_BITS;
	localparam int F         = SAMPLE_FRAC_BITS;
	localparam int AW        = FREQ_W + TUNE_W;
	localparam int MW        = AW + 16;
	localparam int INC_SHIFT = 38 - P;
	localparam int NDIV      = F + 1;

	// configuration
	wave_t               wave_q;
	logic [TUNE_W-1:0]   tune_q;
	logic [PERIOD_W-1:0] period_q;
	logic                wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q   <= WAVE_SAW;
			tune_q   <= TUNE_RST;
			period_q <= PERIOD_RST;
		end else if (wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_WAVE:   wave_q   <= wave_t'(pwdata[1:0]);
				REG_TUNE:   tune_q   <= pwdata[TUNE_W-1:0];
				REG_PERIOD: period_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_WAVE:   prdata = {30'd0, wave_q};
			REG_TUNE:   prdata = {16'd0, tune_q};
			REG_PERIOD: prdata = period_q;
			default:    prdata = '0;
		endcase
	end

	// pipeline control
	logic out_vld_q;
	logic en;

	assign en          = !out_vld_q || out_ch.ready;
	assign in_ch.ready = en;

	// stage 1: frequency times tune ratio
	logic          vld_s1;
	logic [P-1:0]  phase_s1;
	logic [AW-1:0] a_s1;

	// stage 2: partial products with sample period
	logic          vld_s2;
	logic [P-1:0]  phase_s2;
	logic [MW-1:0] hi_s2;
	logic [MW-1:0] lo_s2;

	// stage 3: saturated increment
	logic          vld_s3;
	logic [P-1:0]  phase_s3;
	logic [P-1:0]  inc_s3;
	logic [MW:0]   sum3;
	logic [MW:0]   incw3;

	always_comb begin
		sum3  = {1'b0, hi_s2} + {17'd0, lo_s2[MW-1:16]};
		incw3 = sum3 >> INC_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_ch.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1 <= in_ch.phase_in;
			a_s1     <= in_ch.freq_hz * tune_q;
			phase_s2 <= phase_s1;
			hi_s2    <= a_s1 * period_q[31:16];
			lo_s2    <= a_s1 * period_q[15:0];
			phase_s3 <= phase_s2;
			inc_s3   <= (|incw3[MW:P]) ? {P{1'b1}} : incw3[P-1:0];
		end
	end

	// stage 4: new phase, branch selection, naive waveform
	logic [P:0]            tsum4;
	logic [P-1:0]          t4;
	logic [P-1:0]          t24;
	logic [P:0]            tpa4;
	logic [P:0]            tpb4;
	logic [P:0]            one4;
	logic                  tka4, nga4, tkb4, ngb4;
	logic [P-1:0]          da4, db4;
	logic signed [P+1:0]   v4;
	logic signed [P+F+1:0] vx4;
	logic signed [P+F+1:0] sw4;
	logic signed [F+1:0]   base4;

	always_comb begin
		one4  = {1'b1, {P{1'b0}}};
		tsum4 = {1'b0, phase_s3} + {1'b0, inc_s3};
		t4    = tsum4[P-1:0];
		t24   = t4 ^ {1'b1, {(P-1){1'b0}}};
		tpa4  = {1'b0, t4} + {1'b0, inc_s3};
		tpb4  = {1'b0, t24} + {1'b0, inc_s3};
		tka4 = 1'b0; nga4 = 1'b0; da4 = '0;
		if (t4 < inc_s3) begin
			tka4 = 1'b1; nga4 = 1'b1; da4 = inc_s3 - t4;
		end else if (tpa4 > one4) begin
			tka4 = 1'b1; da4 = tpa4[P-1:0];
		end
		tkb4 = 1'b0; ngb4 = 1'b0; db4 = '0;
		if (t24 < inc_s3) begin
			tkb4 = 1'b1; ngb4 = 1'b1; db4 = inc_s3 - t24;
		end else if (tpb4 > one4) begin
			tkb4 = 1'b1; db4 = tpb4[P-1:0];
		end
		v4  = $signed({1'b0, t4, 1'b0}) - $signed({2'b01, {P{1'b0}}});
		vx4 = {v4, {F{1'b0}}};
		sw4 = vx4 >>> P;
		if (wave_q == WAVE_SQR)
			base4 = t4[P-1] ? -$signed({2'b01, {F{1'b0}}}) : $signed({2'b01, {F{1'b0}}});
		else
			base4 = sw4[F+1:0];
	end

	// divider pipeline: index 0 is stage 4, each step resolves one quotient bit
	logic                vld_sd  [0:NDIV];
	logic [P-1:0]        t_sd    [0:NDIV];
	logic [P-1:0]        dt_sd   [0:NDIV];
	logic                tka_sd  [0:NDIV];
	logic                nga_sd  [0:NDIV];
	logic                tkb_sd  [0:NDIV];
	logic                ngb_sd  [0:NDIV];
	logic signed [F+1:0] base_sd [0:NDIV];
	logic [P-1:0]        ra_sd   [0:NDIV];
	logic [P-1:0]        rb_sd   [0:NDIV];
	logic [F:0]          qa_sd   [0:NDIV];
	logic [F:0]          qb_sd   [0:NDIV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_sd[0] <= 1'b0;
		else if (en)
			vld_sd[0] <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_sd[0]    <= t4;
			dt_sd[0]   <= inc_s3;
			tka_sd[0]  <= tka4;
			nga_sd[0]  <= nga4;
			tkb_sd[0]  <= tkb4;
			ngb_sd[0]  <= ngb4;
			base_sd[0] <= base4;
			ra_sd[0]   <= da4;
			rb_sd[0]   <= db4;
			qa_sd[0]   <= '0;
			qb_sd[0]   <= '0;
		end
	end

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic [P:0] rra, rrb;
		logic       gea, geb;
		logic [P:0] nra, nrb;

		always_comb begin
			if (k == 0) begin
				rra = {1'b0, ra_sd[k]};
				rrb = {1'b0, rb_sd[k]};
			end else begin
				rra = {ra_sd[k], 1'b0};
				rrb = {rb_sd[k], 1'b0};
			end
			gea = rra >= {1'b0, dt_sd[k]};
			geb = rrb >= {1'b0, dt_sd[k]};
			nra = gea ? rra - {1'b0, dt_sd[k]} : rra;
			nrb = geb ? rrb - {1'b0, dt_sd[k]} : rrb;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_sd[k+1] <= 1'b0;
			else if (en)
				vld_sd[k+1] <= vld_sd[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				t_sd[k+1]    <= t_sd[k];
				dt_sd[k+1]   <= dt_sd[k];
				tka_sd[k+1]  <= tka_sd[k];
				nga_sd[k+1]  <= nga_sd[k];
				tkb_sd[k+1]  <= tkb_sd[k];
				ngb_sd[k+1]  <= ngb_sd[k];
				base_sd[k+1] <= base_sd[k];
				ra_sd[k+1]   <= nra[P-1:0];
				rb_sd[k+1]   <= nrb[P-1:0];
				qa_sd[k+1]   <= {qa_sd[k][F-1:0], gea};
				qb_sd[k+1]   <= {qb_sd[k][F-1:0], geb};
			end
		end
	end

	// square stage
	logic                vld_sq;
	logic [P-1:0]        t_sq;
	logic                tka_sq, nga_sq, tkb_sq, ngb_sq;
	logic signed [F+1:0] base_sq;
	logic [2*F+1:0]      pa_sq, pb_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_sq <= 1'b0;
		else if (en)
			vld_sq <= vld_sd[NDIV];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_sq    <= t_sd[NDIV];
			tka_sq  <= tka_sd[NDIV];
			nga_sq  <= nga_sd[NDIV];
			tkb_sq  <= tkb_sd[NDIV];
			ngb_sq  <= ngb_sd[NDIV];
			base_sq <= base_sd[NDIV];
			pa_sq   <= qa_sd[NDIV] * qa_sd[NDIV];
			pb_sq   <= qb_sd[NDIV] * qb_sd[NDIV];
		end
	end

	// sum and saturate
	logic signed [F+3:0] ta, tb, acc;
	logic signed [F+3:0] smax, smin;
	logic signed [F+2:0] sat;

	always_comb begin
		smax = $signed({2'b00, {(F+2){1'b1}}});
		smin = $signed({2'b11, {(F+2){1'b0}}});
		ta = '0;
		tb = '0;
		if (tka_sq)
			ta = nga_sq ? -$signed({3'b000, pa_sq[2*F:F]})
			            :  $signed({3'b000, pa_sq[2*F:F]});
		if (tkb_sq)
			tb = ngb_sq ? -$signed({3'b000, pb_sq[2*F:F]})
			            :  $signed({3'b000, pb_sq[2*F:F]});
		case (wave_q)
			WAVE_SAW: acc = {{2{base_sq[F+1]}}, base_sq} - ta;
			WAVE_SQR: acc = {{2{base_sq[F+1]}}, base_sq} + ta - tb;
			default:  acc = '0;
		endcase
		if (acc > smax)
			sat = smax[F+2:0];
		else if (acc < smin)
			sat = smin[F+2:0];
		else
			sat = acc[F+2:0];
	end

	logic [P-1:0]        phase_q;
	logic signed [F+2:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= vld_sq;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_q  <= t_sq;
			sample_q <= sat;
		end
	end

	assign out_ch.valid      = out_vld_q;
	assign out_ch.phase_out  = phase_q;
	assign out_ch.sample_out = sample_q;

`ifndef SYNTH
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s1) && $stable(vld_s3) && $stable(vld_sq))
		else $error("pipeline moved during stall");

	a_quiet_modes: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (wave_q == WAVE_TRI || wave_q == WAVE_OFF) |-> sample_q == '0)
		else $error("nonzero sample in quiet mode");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sd[NDIV] && tka_sd[NDIV] |-> qa_sd[NDIV] <= {1'b1, {F{1'b0}}})
		else $error("quotient out of range");
`endif

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import pbo_pkg::*;

	localparam int PB = 24;
	localparam int FB = 15;
	localparam int LAT = FB + 8;
	localparam longint PH_ONE = 64'd1 << PB;

	typedef struct {
		logic [PB-1:0] phase;
		logic [23:0]   freq;
	} voice_t;

	typedef struct {
		logic [PB-1:0]        phase;
		logic signed [FB+2:0] smp;
	} tone_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	pbo_in_if #(.PHASE_BITS(PB)) in_ch ();
	pbo_out_if #(.PHASE_BITS(PB), .SAMPLE_FRAC_BITS(FB)) out_ch ();

	polyblep_oscillator_sample dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #1 clk = ~clk;

	wave_t          m_wave = WAVE_SAW;
	logic [15:0]    m_tune = TUNE_RST;
	logic [31:0]    m_period = PERIOD_RST;

	voice_t voice_q[$];
	tone_t  tone_q[$];
	int mismatches = 0;
	int n_sent = 0, n_got = 0;
	int src_idle = 0, snk_stall = 0;
	logic hold_go = 1'b0;
	logic hold_on = 1'b0;

	function automatic longint blep_term(longint t, longint dt);
		longint d, q;
		if (t < dt) begin
			d = dt - t;
			q = (d << FB) / dt;
			return -((q * q) >>> FB);
		end
		if (t + dt > PH_ONE) begin
			d = t + dt - PH_ONE;
			q = (d << FB) / dt;
			return (q * q) >>> FB;
		end
		return 0;
	endfunction

	function automatic tone_t next_tone(voice_t v);
		tone_t r;
		logic [127:0] prod;
		longint inc, t, s, saw;
		prod = 128'(v.freq) * 128'(m_tune) * 128'(m_period);
		prod = prod >> (54 - PB);
		inc = (prod >= 128'(PH_ONE)) ? PH_ONE - 1 : longint'(prod);
		t = (longint'(v.phase) + inc) % PH_ONE;
		s = 0;
		if (m_wave == WAVE_SAW) begin
			saw = ((2 * t - PH_ONE) * (64'sd1 <<< FB)) >>> PB;
			s = saw - blep_term(t, inc);
		end else if (m_wave == WAVE_SQR) begin
			s = (t < PH_ONE / 2) ? (64'sd1 <<< FB) : -(64'sd1 <<< FB);
			s += blep_term(t, inc);
			s -= blep_term((t + PH_ONE / 2) % PH_ONE, inc);
		end
		if (s > (64'sd1 <<< (FB + 2)) - 1) s = (64'sd1 <<< (FB + 2)) - 1;
		if (s < -(64'sd1 <<< (FB + 2))) s = -(64'sd1 <<< (FB + 2));
		r.phase = t[PB-1:0];
		r.smp = s[FB+2:0];
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.phase_in <= '0;
			in_ch.freq_hz <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				tone_q.push_back(next_tone('{in_ch.phase_in, in_ch.freq_hz}));
				n_sent++;
			end
			if ((!in_ch.valid || in_ch.ready) && voice_q.size() > 0
					&& $urandom_range(99) >= src_idle) begin
				voice_t v;
				v = voice_q.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.phase_in <= v.phase;
				in_ch.freq_hz <= v.freq;
			end else if (in_ch.ready) begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off
	initial begin
		wait (hold_go);
		hold_on = 1'b1;
		repeat (300) @(posedge clk);
		hold_on = 1'b0;
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				n_got++;
				if (tone_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected transaction phase=%0h", out_ch.phase_out);
				end else begin
					tone_t e;
					e = tone_q.pop_front();
					if (e.phase !== out_ch.phase_out || e.smp !== out_ch.sample_out) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp phase=%0h smp=%0d got phase=%0h smp=%0d",
								e.phase, e.smp, out_ch.phase_out, out_ch.sample_out);
					end
				end
			end
			if (hold_on) begin
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= snk_stall);
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(idx)); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_WAVE:   m_wave = wave_t'(val[1:0]);
			REG_TUNE:   m_tune = val[15:0];
			REG_PERIOD: m_period = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while ((voice_q.size() > 0 || in_ch.valid || tone_q.size() > 0) && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (LAT + 4) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_freq();
		case ($urandom_range(3))
			0: return 24'($urandom_range(20000 * 256));
			1: return 24'($urandom);
			2: return 24'($urandom_range(255));
			default: return 24'($urandom_range(2000 * 256));
		endcase
	endfunction

	task automatic add_random(int n);
		for (int i = 0; i < n; i++)
			voice_q.push_back('{PB'($urandom), rand_freq()});
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset config
		voice_q.push_back('{24'h0, 24'h0});
		voice_q.push_back('{24'hFFFFFF, 24'h0});
		voice_q.push_back('{24'hFFFFFF, 24'h000100});
		voice_q.push_back('{24'hFFFFFF, 24'hFFFFFF});
		voice_q.push_back('{24'h000000, 24'hFFFFFF});
		voice_q.push_back('{24'h7FFFFF, 24'h010000});
		voice_q.push_back('{24'h800000, 24'h000001});
		voice_q.push_back('{24'hFFFF00, 24'h0AC440});
		drain();
		reg_write(REG_WAVE, 32'(WAVE_SQR));
		voice_q.push_back('{24'h7FFF00, 24'h0AC440});
		voice_q.push_back('{24'h800000, 24'h0AC440});
		voice_q.push_back('{24'hFFFFFF, 24'hFFFFFF});
		voice_q.push_back('{24'h000000, 24'h000001});
		voice_q.push_back('{24'h555555, 24'hAAAAAA});
		drain();
		reg_write(REG_WAVE, 32'(WAVE_TRI));
		voice_q.push_back('{24'h123456, 24'h0AC440});
		drain();
		reg_write(REG_WAVE, 32'(WAVE_OFF));
		voice_q.push_back('{24'hABCDEF, 24'h0AC440});
		drain();
		reg_write(REG_TUNE, 32'hFFFF);
		reg_write(REG_PERIOD, 32'hFFFFFFFF);
		reg_write(REG_WAVE, 32'(WAVE_SAW));
		voice_q.push_back('{24'h000010, 24'h000001});
		voice_q.push_back('{24'hFFFFFF, 24'h000002});
		drain();

		// random phases over settings and idling modes
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin src_idle = 0;  snk_stall = 0;  end
				1: begin src_idle = 86; snk_stall = 0;  end
				2: begin src_idle = 0;  snk_stall = 86; end
				default: begin src_idle = 6; snk_stall = 6; end
			endcase
			reg_write(REG_WAVE, (ph % 3 == 1) ? 32'($urandom_range(3))
				: ((ph % 2) ? 32'(WAVE_SQR) : 32'(WAVE_SAW)));
			case (ph % 3)
				0: reg_write(REG_TUNE, 32'(16'd8192));
				1: reg_write(REG_TUNE, 32'(16'd32768));
				default: reg_write(REG_TUNE, $urandom_range(65535));
			endcase
			case (ph % 4)
				0: reg_write(REG_PERIOD, 32'd1);
				1: reg_write(REG_PERIOD, PERIOD_RST);
				2: reg_write(REG_PERIOD, $urandom);
				default: reg_write(REG_PERIOD, 32'($urandom_range(200000)));
			endcase
			if (ph == 4) hold_go = 1'b1;
			add_random(60);
			drain();
		end
		src_idle = 0; snk_stall = 0;
		drain();

		$display("covered %0d voice transactions, %0d samples, all wave modes and tune/period extremes",
			n_sent, n_got);
		if (mismatches == 0 && tone_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d samples missing", mismatches, tone_q.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end
endmodule

// ----- polyblep_oscillator_sample.f -----
rtl/pbo_pkg.sv
rtl/pbo_if.sv
rtl/polyblep_oscillator_sample.sv
sim/tb_top.sv
